>>> hdl/lru_key_value_cache_defines.svh
// assertion macros shared by the lru key-value cache rtl
// no dependencies; included by modules that carry assertions
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lkvc_pkg.sv
// shared constants and controller/datapath interface types for the lru cache
// no dependencies
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = 32;
    localparam int OUT_FIXED_W = OCC_W + 2 * CNT_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted item, clear trackers
        logic scan_rd;  // read entry at addr for the lookup pass
        logic upd_rd;   // read entry at addr for the recency pass
        logic val_rd;   // read stored value of the matching entry
        logic commit;   // apply the item and load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_upd; // item changes recency ranks
        logic out_free; // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/lru_key_value_cache.sv
// top level of the fully associative lru key-value cache: stream ports,
// field packing, controller and datapath; depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath
//
//  port group   | dir | beat contents
//  -------------+-----+-------------------------------------------------------------
//  s_axis       | in  | tuser: op ; tdata: key, value
//  m_axis       | out | tuser: hit, evicted ; tdata: read_value, evicted_key,
//               |     |   occupancy, hit_count, miss_count
//  cfg          | in  | capacity, written whenever wr_en is high
//
// a get miss runs only the lookup sweep before its commit, any other item the lookup
// and the recency sweep; the sweeps step one entry a cycle through the single read port
// of the key and recency memories
// the next item is accepted while a result waits; only the commit step stalls on it
// synchronous active-low reset empties the cache and clears the counters;
// capacity resets to 16
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_cfg_wr_en,
    input  wire  [lkvc_pkg::CFG_W-1:0]                i_cfg_wr_data,
    input  wire                                       i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // key, value
    input  wire  [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    // op
    input  wire                                       i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  wire                                       i_m_axis_tready,
    // read_value, evicted_key, occupancy, hit_count, miss_count
    output logic [((VALUE_BITS+KEY_BITS+lkvc_pkg::OUT_FIXED_W+7)/8)*8-1:0] o_m_axis_tdata,
    // hit, evicted
    output logic [1:0]                                o_m_axis_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OUT_W = ((VALUE_BITS + KEY_BITS + lkvc_pkg::OUT_FIXED_W + 7) / 8) * 8;
    localparam int RAW_W = VALUE_BITS + KEY_BITS + lkvc_pkg::OUT_FIXED_W;

    lkvc_pkg::t_cmd  w_cmd;
    lkvc_pkg::t_stat w_stat;
    logic [IDX_W-1:0] w_addr;

    logic                         w_hit, w_evicted;
    logic [VALUE_BITS-1:0]        w_read_value;
    logic [KEY_BITS-1:0]          w_evicted_key;
    logic [lkvc_pkg::OCC_W-1:0]   w_occupancy;
    logic [lkvc_pkg::CNT_W-1:0]   w_hit_count, w_miss_count;
    logic [RAW_W-1:0]             w_out_raw;

    lkvc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr)
    );

    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (i_s_axis_tuser),
        .i_key         (i_s_axis_tdata[KEY_BITS-1:0]),
        .i_value       (i_s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .i_cmd         (w_cmd),
        .i_addr        (w_addr),
        .o_stat        (w_stat),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_hit         (w_hit),
        .o_read_value  (w_read_value),
        .o_evicted     (w_evicted),
        .o_evicted_key (w_evicted_key),
        .o_occupancy   (w_occupancy),
        .o_hit_count   (w_hit_count),
        .o_miss_count  (w_miss_count)
    );

    assign w_out_raw = {w_miss_count, w_hit_count, w_occupancy, w_evicted_key, w_read_value};
    assign o_m_axis_tdata = OUT_W'(w_out_raw);
    assign o_m_axis_tuser = {w_evicted, w_hit};

endmodule

`default_nettype wire

>>> hdl/lkvc_ctrl.sv
// sequencer for the lru cache: item accept, lookup sweep, recency sweep, commit
// depends on lkvc_pkg
`default_nettype none

module lkvc_ctrl #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  lkvc_pkg::t_stat            i_stat,
    output lkvc_pkg::t_cmd             o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_addr
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SDRAIN = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_UDRAIN = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_addr     = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_SDRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            // last lookup read lands in the trackers
            S_SDRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.val_rd = 1'b1;
                n_addr       = '0;
                n_state      = i_stat.need_upd ? S_UPD : S_COMMIT;
            end
            S_UPD: begin
                o_cmd.upd_rd = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_UDRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            // last recency write-back
            S_UDRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

`default_nettype wire

>>> hdl/lkvc_datapath.sv
// lru cache datapath: key/value/recency memories, valid bits, lookup trackers,
// counters, capacity register and output register; depends on lkvc_pkg
`default_nettype none

module lkvc_datapath #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire  [lkvc_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  wire                            i_op,
    input  wire  [KEY_BITS-1:0]            i_key,
    input  wire  [VALUE_BITS-1:0]          i_value,
    input  lkvc_pkg::t_cmd                 i_cmd,
    input  wire  [$clog2(ENTRIES)-1:0]     i_addr,
    output lkvc_pkg::t_stat                o_stat,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic                           o_hit,
    output logic [VALUE_BITS-1:0]          o_read_value,
    output logic                           o_evicted,
    output logic [KEY_BITS-1:0]            o_evicted_key,
    output logic [lkvc_pkg::OCC_W-1:0]     o_occupancy,
    output logic [lkvc_pkg::CNT_W-1:0]     o_hit_count,
    output logic [lkvc_pkg::CNT_W-1:0]     o_miss_count
);

`include "lru_key_value_cache_defines.svh"

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = lkvc_pkg::OCC_W;
    localparam int CNT_W = lkvc_pkg::CNT_W;
    localparam int CAP_MAX_I = (ENTRIES > 31) ? 31 : ENTRIES;
    localparam logic [OCC_W-1:0] CAP_MAX = OCC_W'(CAP_MAX_I);

    // storage
    logic [KEY_BITS-1:0]   r_key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_val_mem [ENTRIES];
    logic [IDX_W-1:0]      r_rec_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;

    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic [IDX_W-1:0]      r_rec_q;
    logic                  r_scan_q, r_upd_q;
    logic [IDX_W-1:0]      r_idx_q;

    // current item
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // lookup trackers
    logic                  r_found, r_lru_any, r_free_any;
    logic [IDX_W-1:0]      r_found_idx, r_lru_idx, r_free_idx;
    logic [IDX_W-1:0]      r_found_rec, r_lru_rec;
    logic [KEY_BITS-1:0]   r_lru_key;

    logic [lkvc_pkg::CFG_W-1:0] r_cap;
    logic [OCC_W-1:0]      r_occ;
    logic [CNT_W-1:0]      r_hits, r_misses;

    logic                  r_m_tvalid, r_out_hit, r_out_ev;
    logic [VALUE_BITS-1:0] r_out_rd;
    logic [KEY_BITS-1:0]   r_out_evk;

    logic                  w_cur_valid;
    logic [OCC_W-1:0]      w_eff_cap;
    logic                  w_ev, w_ins, w_out_free;
    logic [IDX_W-1:0]      w_slot, w_rec_new, w_val_wa;
    logic                  w_val_we;
    logic [ENTRIES-1:0]    w_valid_nx;

    assign w_cur_valid = r_valid[r_idx_q];

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = OCC_W'(1);
        end else if (r_cap > CAP_MAX) begin
            w_eff_cap = CAP_MAX;
        end else begin
            w_eff_cap = r_cap;
        end
    end

    assign w_ev  = (r_op == lkvc_pkg::OP_PUT) && !r_found && (r_occ >= w_eff_cap)
                   && r_lru_any;
    assign w_ins = (r_op == lkvc_pkg::OP_PUT) && !r_found && (w_ev || r_free_any);

    // after an eviction the lowest free index is the lower of the two
    always_comb begin
        if (w_ev && !(r_free_any && (r_free_idx < r_lru_idx))) begin
            w_slot = r_lru_idx;
        end else begin
            w_slot = r_free_idx;
        end
    end

    // valid bits after the commit: evicted entry cleared, new entry set
    always_comb begin
        w_valid_nx = r_valid;
        if (w_ev) begin
            w_valid_nx[r_lru_idx] = 1'b0;
        end
        if (w_ins) begin
            w_valid_nx[w_slot] = 1'b1;
        end
    end

    // recency rank for the entry returning from the update read
    always_comb begin
        if (r_found) begin
            if (r_idx_q == r_found_idx) begin
                w_rec_new = '0;
            end else if (w_cur_valid && (r_rec_q < r_found_rec)) begin
                w_rec_new = r_rec_q + 1'b1;
            end else begin
                w_rec_new = r_rec_q;
            end
        end else begin
            if (r_idx_q == w_slot) begin
                w_rec_new = '0;
            end else if (w_cur_valid && !(w_ev && (r_idx_q == r_lru_idx))) begin
                w_rec_new = r_rec_q + 1'b1;
            end else begin
                w_rec_new = r_rec_q;
            end
        end
    end

    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_val_we   = i_cmd.commit && (r_op == lkvc_pkg::OP_PUT) && (r_found || w_ins);
    assign w_val_wa   = r_found ? r_found_idx : w_slot;

    assign o_stat.need_upd = r_found || (r_op == lkvc_pkg::OP_PUT);
    assign o_stat.out_free = w_out_free;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_ins) begin
            r_key_mem[w_slot] <= r_key;
        end
        r_key_q <= r_key_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_val_mem[w_val_wa] <= r_value;
        end
        if (i_cmd.val_rd) begin
            r_val_q <= r_val_mem[r_found_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_upd_q) begin
            r_rec_mem[r_idx_q] <= w_rec_new;
        end
        r_rec_q <= r_rec_mem[i_addr];
    end

    // read pipeline, item capture, tracker payload
    always_ff @(posedge i_clk) begin
        r_idx_q <= i_addr;
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_scan_q) begin
            if (w_cur_valid && (r_key_q == r_key) && !r_found) begin
                r_found_idx <= r_idx_q;
                r_found_rec <= r_rec_q;
            end
            if (w_cur_valid && (!r_lru_any || (r_rec_q > r_lru_rec))) begin
                r_lru_idx <= r_idx_q;
                r_lru_rec <= r_rec_q;
                r_lru_key <= r_key_q;
            end
            if (!w_cur_valid && !r_free_any) begin
                r_free_idx <= r_idx_q;
            end
        end
        if (i_cmd.commit) begin
            r_out_hit <= r_found;
            r_out_ev  <= w_ev;
            r_out_rd  <= ((r_op == lkvc_pkg::OP_GET) && r_found) ? r_val_q : '0;
            r_out_evk <= w_ev ? r_lru_key : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_q   <= 1'b0;
            r_upd_q    <= 1'b0;
            r_found    <= 1'b0;
            r_lru_any  <= 1'b0;
            r_free_any <= 1'b0;
            r_valid    <= '0;
            r_occ      <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_cap      <= lkvc_pkg::CAP_RESET;
            r_m_tvalid <= 1'b0;
        end else begin
            r_scan_q <= i_cmd.scan_rd;
            r_upd_q  <= i_cmd.upd_rd;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_found    <= 1'b0;
                r_lru_any  <= 1'b0;
                r_free_any <= 1'b0;
            end else if (r_scan_q) begin
                if (w_cur_valid && (r_key_q == r_key)) begin
                    r_found <= 1'b1;
                end
                if (w_cur_valid) begin
                    r_lru_any <= 1'b1;
                end else begin
                    r_free_any <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_valid <= w_valid_nx;
                if (w_ins && !w_ev) begin
                    r_occ <= r_occ + 1'b1;
                end
                if ((r_op == lkvc_pkg::OP_GET) && r_found && (r_hits != '1)) begin
                    r_hits <= r_hits + 1'b1;
                end
                if ((r_op == lkvc_pkg::OP_GET) && !r_found && (r_misses != '1)) begin
                    r_misses <= r_misses + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // occupancy and counters only move on commit, which waits for the output
    // register to free up, so they stay in step with the shown beat
    assign o_m_tvalid    = r_m_tvalid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_rd;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evk;
    assign o_occupancy   = r_occ;
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;

    `LKVC_ASSERT(a_evict_inserts, i_clk, i_rst_n, i_cmd.commit && w_ev, w_ins,
                 "eviction without insert")
    `LKVC_ASSERT(a_grow_below_cap, i_clk, i_rst_n, i_cmd.commit && w_ins && !w_ev,
                 r_occ < w_eff_cap, "occupancy grows past capacity")
    `LKVC_ASSERT(a_commit_free, i_clk, i_rst_n, i_cmd.commit, w_out_free,
                 "commit over a held result")
    `LKVC_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, i_cmd.commit, r_m_tvalid,
                      "committed result not shown")
    `LKVC_ASSERT(a_evict_is_miss, i_clk, i_rst_n, r_m_tvalid && r_out_ev, !r_out_hit,
                 "eviction on a hit")

endmodule

`default_nettype wire
